>>> rtl/scd_pkg.sv
package scd_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned STALE_W = 16;
  localparam int unsigned WIN_W   = 8;
  localparam int unsigned TOT_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_SECONDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_LIMIT = 2'd2;

  // Register reset values
  localparam logic [ADDR_W-1:0]  MASK_RST  = 32'hFFFF_FF00;
  localparam logic [STALE_W-1:0] STALE_RST = 16'd300;
  localparam logic [WIN_W-1:0]   LIMIT_RST = 8'd5;

  localparam logic [WIN_W-1:0] WIN_MAX = {WIN_W{1'b1}};
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  typedef enum logic [1:0] {
    OUT_COUNTED = 2'd0,
    OUT_NEW     = 2'd1,
    OUT_DROPPED = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [ADDR_W-1:0] subnet;
    logic [WIN_W-1:0]  win_count;
    logic [TOT_W-1:0]  tot_count;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] first_time;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  subnet_mask;
    logic [STALE_W-1:0] stale_seconds;
    logic [WIN_W-1:0]   connect_limit;
  } cfg_t;

  // Per-entry status from the update logic to the sequencer
  typedef struct packed {
    logic              hit;
    logic              empty;
    logic              alert;
    logic [TOT_W-1:0]  total;
    logic [TIME_W-1:0] elapsed;
  } upd_t;

endpackage

>>> rtl/scd_entry_ram.sv
module scd_entry_ram (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [scd_pkg::IDX_W-1:0] wr_addr_i,
  input  scd_pkg::entry_t       wr_data_i,
  input  logic                  rd_en_i,
  input  logic [scd_pkg::IDX_W-1:0] rd_addr_i,
  output scd_pkg::entry_t       rd_data_o
);
  import scd_pkg::*;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/scd_cfg_regs.sv
module scd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output scd_pkg::cfg_t                  cfg_o
);
  import scd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SUBNET_MASK:   cfg_d.subnet_mask   = cfg_data_i[ADDR_W-1:0];
        CFG_STALE_SECONDS: cfg_d.stale_seconds = cfg_data_i[STALE_W-1:0];
        CFG_CONNECT_LIMIT: cfg_d.connect_limit = cfg_data_i[WIN_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.subnet_mask   <= MASK_RST;
      cfg_q.stale_seconds <= STALE_RST;
      cfg_q.connect_limit <= LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

endmodule

>>> rtl/scd_entry_update.sv
module scd_entry_update (
  input  scd_pkg::entry_t              rd_entry_i,
  input  logic [scd_pkg::ADDR_W-1:0]   key_i,
  input  logic [scd_pkg::TIME_W-1:0]   now_i,
  input  scd_pkg::cfg_t                cfg_i,
  output scd_pkg::entry_t              wr_entry_o,
  output scd_pkg::upd_t                upd_o
);
  import scd_pkg::*;

  logic              occupied;
  logic              hit;
  logic              stale;
  logic [TIME_W:0]   stale_sum;
  logic [WIN_W-1:0]  win_base;
  logic [WIN_W-1:0]  win_inc;
  logic [TOT_W-1:0]  tot_base;
  logic [TOT_W-1:0]  tot_inc;
  logic [TIME_W-1:0] first_base;
  logic [TIME_W-1:0] age;
  logic              alert;

  // Classify the slot
  assign occupied  = (rd_entry_i.subnet != '0);
  assign hit       = occupied && (rd_entry_i.subnet == key_i);
  assign stale_sum = {1'b0, rd_entry_i.last_time} + {{(TIME_W+1-STALE_W){1'b0}}, cfg_i.stale_seconds};
  assign stale     = (stale_sum < {1'b0, now_i});

  // Restart a stale hit, then count with saturation
  assign win_base   = stale ? '0 : rd_entry_i.win_count;
  assign tot_base   = stale ? '0 : rd_entry_i.tot_count;
  assign first_base = stale ? now_i : rd_entry_i.first_time;
  assign win_inc    = (win_base == WIN_MAX) ? WIN_MAX : win_base + WIN_W'(1);
  assign tot_inc    = (tot_base == TOT_MAX) ? TOT_MAX : tot_base + TOT_W'(1);
  // A limit of zero alerts on every count, as the count is at least one
  assign alert      = (win_inc >= cfg_i.connect_limit);
  assign age        = stale ? '0 : now_i - rd_entry_i.first_time;

  always_comb begin
    wr_entry_o = rd_entry_i;
    if (hit) begin
      wr_entry_o.win_count  = alert ? '0 : win_inc;
      wr_entry_o.tot_count  = tot_inc;
      wr_entry_o.first_time = first_base;
      wr_entry_o.last_time  = now_i;
    end else if (occupied && stale) begin
      // Free an idle entry of another subnet
      wr_entry_o.subnet = '0;
    end
  end

  assign upd_o.hit     = hit;
  assign upd_o.empty   = !occupied;
  assign upd_o.alert   = hit && alert;
  assign upd_o.total   = tot_inc;
  assign upd_o.elapsed = age;

endmodule

>>> rtl/subnet_connect_rate_detector.sv
// Channel  Handshake                  Payload
// -------  -------------------------  ------------------------------------------------
// in       in_valid_i / in_ready_o    source_address_i, now_seconds_i
// out      out_valid_o / out_ready_i  alert_o, outcome_o, total_connects_o,
//                                     elapsed_seconds_o
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// From acceptance to result a beat scans all TABLE_ENTRIES slots, a pace set
// by the single read port of the entry memory, swept one slot a cycle.
// A new beat is taken only once the last one has loaded its result into the output register.
// After reset a clearing pass empties the table; in_ready_o stays low meanwhile,
// and configuration writes are taken at all times.
// The output register holds a result until taken; a new beat is accepted while it
// waits, and its scan stalls at the end until the register frees.
module subnet_connect_rate_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [scd_pkg::ADDR_W-1:0]     source_address_i,
  input  logic [scd_pkg::TIME_W-1:0]     now_seconds_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           alert_o,
  output logic [1:0]                     outcome_o,
  output logic [scd_pkg::TOT_W-1:0]      total_connects_o,
  output logic [scd_pkg::TIME_W-1:0]     elapsed_seconds_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import scd_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_e            state_q;
  logic [IDX_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              rd_vld_q;
  logic [ADDR_W-1:0] key_q;
  logic [TIME_W-1:0] now_q;
  logic              found_q;
  logic              have_empty_q;
  logic [IDX_W-1:0]  empty_slot_q;
  logic              res_alert_q;
  logic [TOT_W-1:0]  res_total_q;
  logic [TIME_W-1:0] res_elapsed_q;
  logic              out_valid_q;
  logic              out_alert_q;
  outcome_e          out_outcome_q;
  logic [TOT_W-1:0]  out_total_q;
  logic [TIME_W-1:0] out_elapsed_q;

  cfg_t              cfg;
  entry_t            rd_entry;
  entry_t            upd_entry;
  entry_t            ins_entry;
  entry_t            wr_entry;
  upd_t              upd;
  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  wr_addr;
  logic              in_fire;
  logic              can_finish;
  logic              insert;
  outcome_e          outcome;

  scd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  scd_entry_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (mem_re),
    .rd_addr_i (cnt_q),
    .rd_data_o (rd_entry)
  );

  scd_entry_update u_upd (
    .rd_entry_i (rd_entry),
    .key_i      (key_q),
    .now_i      (now_q),
    .cfg_i      (cfg),
    .wr_entry_o (upd_entry),
    .upd_o      (upd)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign can_finish = !out_valid_q || out_ready_i;
  assign insert     = !found_q && have_empty_q;

  always_comb begin
    if (found_q) begin
      outcome = OUT_COUNTED;
    end else if (have_empty_q) begin
      outcome = OUT_NEW;
    end else begin
      outcome = OUT_DROPPED;
    end
  end

  // Fresh entry for a subnet not yet in the table
  always_comb begin
    ins_entry.subnet     = key_q;
    ins_entry.win_count  = WIN_W'(1);
    ins_entry.tot_count  = TOT_W'(1);
    ins_entry.last_time  = now_q;
    ins_entry.first_time = now_q;
  end

  // Memory port control: reads advance one slot ahead of write-back, so a
  // read never meets a write to the same slot
  assign mem_re = (state_q == ST_SCAN);

  always_comb begin
    mem_we   = 1'b0;
    wr_addr  = rd_idx_q;
    wr_entry = upd_entry;
    if (state_q == ST_CLEAR) begin
      mem_we   = 1'b1;
      wr_addr  = cnt_q;
      wr_entry = '0;
    end else if (rd_vld_q) begin
      mem_we = 1'b1;
    end else if ((state_q == ST_DONE) && can_finish && insert) begin
      mem_we   = 1'b1;
      wr_addr  = empty_slot_q;
      wr_entry = ins_entry;
    end
  end

  // Sequencer, accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      cnt_q         <= '0;
      rd_idx_q      <= '0;
      rd_vld_q      <= 1'b0;
      key_q         <= '0;
      now_q         <= '0;
      found_q       <= 1'b0;
      have_empty_q  <= 1'b0;
      empty_slot_q  <= '0;
      res_alert_q   <= 1'b0;
      res_total_q   <= '0;
      res_elapsed_q <= '0;
      out_valid_q   <= 1'b0;
      out_alert_q   <= 1'b0;
      out_outcome_q <= OUT_COUNTED;
      out_total_q   <= '0;
      out_elapsed_q <= '0;
    end else begin
      // Drop the result once taken, unless a new one replaces it
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      // Fold in the slot whose read data arrived
      rd_vld_q <= (state_q == ST_SCAN);
      rd_idx_q <= cnt_q;
      if (rd_vld_q) begin
        if (upd.hit) begin
          found_q <= 1'b1;
        end
        if (upd.alert) begin
          res_alert_q   <= 1'b1;
          res_total_q   <= upd.total;
          res_elapsed_q <= upd.elapsed;
        end
        if (upd.empty && !have_empty_q) begin
          have_empty_q <= 1'b1;
          empty_slot_q <= rd_idx_q;
        end
      end

      unique case (state_q)
        ST_CLEAR: begin
          if (cnt_q == LAST_IDX) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            key_q         <= source_address_i & cfg.subnet_mask;
            now_q         <= now_seconds_i;
            found_q       <= 1'b0;
            have_empty_q  <= 1'b0;
            res_alert_q   <= 1'b0;
            res_total_q   <= '0;
            res_elapsed_q <= '0;
            cnt_q         <= '0;
            state_q       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_q == LAST_IDX) begin
            cnt_q   <= '0;
            state_q <= ST_TAIL;
          end else begin
            cnt_q <= cnt_q + IDX_W'(1);
          end
        end
        ST_TAIL: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the output register frees
          if (can_finish) begin
            out_valid_q   <= 1'b1;
            out_alert_q   <= res_alert_q;
            out_outcome_q <= outcome;
            out_total_q   <= res_total_q;
            out_elapsed_q <= res_elapsed_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign alert_o           = out_alert_q;
  assign outcome_o         = out_outcome_q;
  assign total_connects_o  = out_total_q;
  assign elapsed_seconds_o = out_elapsed_q;

  // Write-back never lands on the slot being read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && (state_q == ST_SCAN)) |-> (rd_idx_q != cnt_q))
    else $error("write-back collides with scan read");

  // An alert only comes from an existing entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alert_o) |-> (outcome_o == OUT_COUNTED))
    else $error("alert on a new or dropped beat");

  // Without an alert the report fields are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !alert_o) |-> ((total_connects_o == '0) && (elapsed_seconds_o == '0)))
    else $error("report fields set without alert");

  // An alerting entry has counted at least once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alert_o) |-> (total_connects_o != '0))
    else $error("alert with zero total");

  // An accepted beat starts the scan at slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ((state_q == ST_SCAN) && (cnt_q == '0)))
    else $error("scan did not start");

endmodule
